>>> design/ecc_pkg.sv
`default_nettype none

package ecc_pkg;

  localparam int TABLE_DEPTH = 2048;
  localparam int SAMPLE_STEP = 10;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  // rev_pos / SAMPLE_STEP as a multiply by a rounded-up reciprocal
  localparam int DIV_SHIFT = 16 + $clog2(SAMPLE_STEP);
  localparam int DIV_RECIP = (2 ** DIV_SHIFT + SAMPLE_STEP - 1) / SAMPLE_STEP;
  localparam int PROD_W    = DIV_SHIFT + 16;

  localparam int READ_OFFSET = 2;
  localparam logic signed [15:0] READ_SCALE = 16'sh3333;
  localparam int SCALE_SHIFT = 15;

  localparam logic [2:0] PH_INIT      = 3'd0;
  localparam logic [2:0] PH_START_FWD = 3'd1;
  localparam logic [2:0] PH_SET_FWD   = 3'd2;
  localparam logic [2:0] PH_CAP_FWD   = 3'd3;
  localparam logic [2:0] PH_SET_REV   = 3'd4;
  localparam logic [2:0] PH_CAP_REV   = 3'd5;
  localparam logic [2:0] PH_CENTER    = 3'd6;

  localparam logic [2:0] REG_DRIVE_LEVEL     = 3'd0;
  localparam logic [2:0] REG_CENTER_LEVEL    = 3'd1;
  localparam logic [2:0] REG_VELOCITY_MARGIN = 3'd2;
  localparam logic [2:0] REG_SETTLE_TARGET   = 3'd3;
  localparam logic [2:0] REG_CENTER_MARGIN   = 3'd4;
  localparam logic [2:0] REG_PERIOD_COUNTS   = 3'd5;
  localparam logic [2:0] REG_SMOOTHING_SHIFT = 3'd6;
  localparam logic [2:0] REG_WRAP_LENGTH     = 3'd7;

  localparam logic [14:0] RST_DRIVE_LEVEL     = 15'd327;
  localparam logic [14:0] RST_CENTER_LEVEL    = 15'd655;
  localparam logic [14:0] RST_VELOCITY_MARGIN = 15'd32;
  localparam logic [15:0] RST_SETTLE_TARGET   = 16'd1000;
  localparam logic [14:0] RST_CENTER_MARGIN   = 15'd100;
  localparam logic [15:0] RST_PERIOD_COUNTS   = 16'd0;
  localparam logic [3:0]  RST_SMOOTHING_SHIFT = 4'd3;
  localparam logic [15:0] RST_WRAP_LENGTH     = 16'd0;

endpackage

`default_nettype wire

>>> design/encoder_correction_calibrator.sv
`default_nettype none

// Encoder correction calibrator.
// Input channel: a transaction is taken when start is high and busy is low.
// in_kind 0 is a calibration sample that advances the seven-phase sequence,
// in_kind 1 reads a forward or reverse correction table entry.
// Result channel: one result per transaction, shown for exactly one cycle
// with out_strobe high; the receiver has no way to hold it off.
// A sample is handled in ST_EXEC and its result registered; a read passes
// ST_EXEC (index math, memory read), ST_RDATA (the Q15 multiply) and
// ST_SCALE (saturation) before its result is registered.
// A new transaction can be accepted in the cycle the result is shown.
// Config port: cfg_valid/cfg_ready with cfg_index and cfg_data, always
// ready; write only while no transaction is in flight.
// Reset (synchronous, rst_n low) restores register defaults and the
// sequence, then both tables are cleared by a pass over all 2048 entries,
// one entry per cycle, during which busy stays high.

module encoder_correction_calibrator (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic               in_kind,
  input  wire logic signed [15:0] in_speed,
  input  wire logic signed [31:0] in_angle_pos,
  input  wire logic        [15:0] in_rev_pos,
  input  wire logic signed [15:0] in_error_sample,
  input  wire logic               in_rev_done,
  input  wire logic               in_reverse_dir,
  output      logic               out_strobe,
  output      logic signed [15:0] out_drive_out,
  output      logic               out_reset_ctrl,
  output      logic               out_arm_rev,
  output      logic               out_clear_rev,
  output      logic               out_done_res,
  output      logic signed [15:0] out_scaled_correction,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic        [2:0]  cfg_index,
  input  wire logic        [15:0] cfg_data
);

  localparam int AW = ecc_pkg::ADDR_W;
  localparam int PW = ecc_pkg::PROD_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_RDATA = 3'd3;
  localparam logic [2:0] ST_SCALE = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  logic [14:0] drive_level_r, center_level_r, velocity_margin_r, center_margin_r;
  logic [15:0] settle_target_r, period_counts_r, wrap_length_r;
  logic [3:0]  smoothing_shift_r;

  logic [2:0]         phase_r, phase_nxt;
  logic signed [15:0] held_drive_r, held_drive_nxt;
  logic [15:0]        settle_cnt_r, settle_cnt_nxt;
  logic [15:0]        sweep_start_r, sweep_start_nxt;
  logic signed [15:0] filter_acc_r, filter_acc_nxt;
  logic               record_valid_r, record_valid_nxt;

  logic               kind_r;
  logic signed [15:0] speed_r;
  logic signed [31:0] angle_r;
  logic [15:0]        rev_pos_r;
  logic signed [15:0] err_r;
  logic               rev_done_r;
  logic               rdir_r;
  logic [PW-1:0]      quot_prod_r;
  logic               rd_ok_r, rd_ok_nxt;
  logic signed [31:0] scale_prod_r;

  logic               strobe_r, strobe_nxt;
  logic signed [15:0] drive_o_r, drive_o_nxt;
  logic               rst_o_r, rst_o_nxt, arm_o_r, arm_o_nxt;
  logic               clr_o_r, clr_o_nxt, done_o_r, done_o_nxt;
  logic signed [15:0] corr_o_r, corr_o_nxt;

  logic accept;
  logic [15:0] quot;
  logic [15:0] quot_times;
  logic on_step, in_table;
  logic signed [15:0] speed_abs, win_v;
  logic signed [17:0] win_v18, win_lo, win_hi;
  logic win_ok;
  logic [15:0] settle_inc;
  logic settle_ok, pos_ok, center_ok, pos_positive;
  logic signed [16:0] filt_diff, filt_step, filt_sum;
  logic signed [18:0] rd_base, rd_len, rd_lenm1, rd_idx;
  logic rd_in_range;
  logic [AW-1:0] rd_addr;
  logic cap_hit;

  logic          ram_we_fwd, ram_we_rev;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [15:0]   fwd_rdata, rev_rdata;
  logic signed [15:0] entry;
  logic signed [16:0] scaled_hi;
  logic signed [15:0] scaled_sat;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // quotient and step check
  assign quot       = quot_prod_r[ecc_pkg::DIV_SHIFT +: 16];
  assign quot_times = 16'(32'(quot) * 32'(ecc_pkg::SAMPLE_STEP));
  assign on_step    = (quot_times == rev_pos_r);
  assign in_table   = ({1'b0, quot} < 17'(ecc_pkg::TABLE_DEPTH));

  // velocity window, reverse uses magnitude with the most negative code kept
  assign speed_abs = (speed_r[15] && (speed_r != 16'sh8000)) ? -speed_r : speed_r;
  assign win_v     = (phase_r == ecc_pkg::PH_SET_REV) ? speed_abs : speed_r;
  assign win_v18   = 18'(win_v);
  assign win_lo    = $signed({3'b000, drive_level_r}) - $signed({3'b000, velocity_margin_r});
  assign win_hi    = $signed({3'b000, drive_level_r}) + $signed({3'b000, velocity_margin_r});
  assign win_ok    = (win_v18 >= win_lo) && (win_v18 <= win_hi);

  assign settle_inc = (settle_cnt_r == 16'hFFFF) ? settle_cnt_r : settle_cnt_r + 16'd1;
  assign settle_ok  = (settle_inc >= settle_target_r);

  assign pos_ok       = (angle_r >= $signed({17'd0, period_counts_r[15:1]}));
  assign center_ok    = (angle_r >= -$signed({17'd0, center_margin_r})) &&
                        (angle_r <= $signed({17'd0, center_margin_r}));
  assign pos_positive = !angle_r[31] && (angle_r != 32'sd0);

  // first-order smoothing, floor shift
  assign filt_diff = 17'(err_r) - 17'(filter_acc_r);
  assign filt_step = filt_diff >>> smoothing_shift_r;
  assign filt_sum  = 17'(filter_acc_r) + filt_step;

  // read index with wrap
  assign rd_base  = rdir_r ? $signed({3'b000, quot}) - 19'sd2 + 19'sd0
                           : $signed({3'b000, quot}) + 19'(ecc_pkg::READ_OFFSET);
  assign rd_len   = $signed({3'b000, wrap_length_r});
  assign rd_lenm1 = rd_len - 19'sd1;

  always_comb begin
    if (rd_base < 19'sd0) begin
      rd_idx = rd_base + rd_lenm1;
    end else if (rd_base >= rd_len) begin
      rd_idx = rd_base - rd_lenm1;
    end else begin
      rd_idx = rd_base;
    end
  end

  assign rd_in_range = !rd_idx[18] && (rd_idx < 19'(ecc_pkg::TABLE_DEPTH));
  assign rd_addr     = rd_idx[AW-1:0];

  assign cap_hit = (state_r == ST_EXEC) && !kind_r && on_step && in_table;

  always_comb begin
    ram_we_fwd = 1'b0;
    ram_we_rev = 1'b0;
    ram_waddr  = quot[AW-1:0];
    ram_wdata  = 16'(filt_sum);
    if (state_r == ST_CLEAR) begin
      ram_we_fwd = 1'b1;
      ram_we_rev = 1'b1;
      ram_waddr  = clr_addr_r;
      ram_wdata  = '0;
    end else if (cap_hit) begin
      ram_we_fwd = (phase_r == ecc_pkg::PH_CAP_FWD);
      ram_we_rev = (phase_r == ecc_pkg::PH_CAP_REV);
    end
  end

  assign ram_re = (state_r == ST_EXEC) && kind_r;

  ecc_ram #(
    .WIDTH(16),
    .DEPTH(ecc_pkg::TABLE_DEPTH)
  ) u_fwd_ram (
    .clk  (clk),
    .we   (ram_we_fwd),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(rd_addr),
    .rdata(fwd_rdata)
  );

  ecc_ram #(
    .WIDTH(16),
    .DEPTH(ecc_pkg::TABLE_DEPTH)
  ) u_rev_ram (
    .clk  (clk),
    .we   (ram_we_rev),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(rd_addr),
    .rdata(rev_rdata)
  );

  assign entry     = rdir_r ? $signed(rev_rdata) : $signed(fwd_rdata);
  assign scaled_hi = 17'(scale_prod_r >>> ecc_pkg::SCALE_SHIFT);

  always_comb begin
    if (scaled_hi > 17'sd32767) begin
      scaled_sat = 16'sh7FFF;
    end else if (scaled_hi < -17'sd32768) begin
      scaled_sat = 16'sh8000;
    end else begin
      scaled_sat = 16'(scaled_hi);
    end
  end

  always_comb begin
    state_nxt        = state_r;
    clr_addr_nxt     = clr_addr_r;
    phase_nxt        = phase_r;
    held_drive_nxt   = held_drive_r;
    settle_cnt_nxt   = settle_cnt_r;
    sweep_start_nxt  = sweep_start_r;
    filter_acc_nxt   = filter_acc_r;
    record_valid_nxt = record_valid_r;
    rd_ok_nxt        = rd_ok_r;
    strobe_nxt       = 1'b0;
    drive_o_nxt      = drive_o_r;
    rst_o_nxt        = 1'b0;
    arm_o_nxt        = 1'b0;
    clr_o_nxt        = 1'b0;
    done_o_nxt       = 1'b0;
    corr_o_nxt       = '0;

    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(ecc_pkg::TABLE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (kind_r) begin
          rd_ok_nxt = record_valid_r && rd_in_range;
          state_nxt = ST_RDATA;
        end else begin
          case (phase_r)
            ecc_pkg::PH_INIT: begin
              held_drive_nxt = '0;
              phase_nxt      = ecc_pkg::PH_START_FWD;
              rst_o_nxt      = 1'b1;
            end
            ecc_pkg::PH_START_FWD: begin
              held_drive_nxt = $signed({1'b0, drive_level_r});
              phase_nxt      = ecc_pkg::PH_SET_FWD;
            end
            ecc_pkg::PH_SET_FWD, ecc_pkg::PH_SET_REV: begin
              settle_cnt_nxt = settle_inc;
              if (settle_ok && win_ok && (pos_ok || (phase_r == ecc_pkg::PH_SET_REV))) begin
                settle_cnt_nxt  = '0;
                sweep_start_nxt = rev_pos_r;
                phase_nxt       = (phase_r == ecc_pkg::PH_SET_FWD) ? ecc_pkg::PH_CAP_FWD
                                                                   : ecc_pkg::PH_CAP_REV;
                arm_o_nxt       = 1'b1;
              end
            end
            ecc_pkg::PH_CAP_FWD, ecc_pkg::PH_CAP_REV: begin
              if (on_step && in_table) begin
                filter_acc_nxt = 16'(filt_sum);
              end
              if (rev_done_r && (rev_pos_r == sweep_start_r)) begin
                clr_o_nxt = 1'b1;
                if (phase_r == ecc_pkg::PH_CAP_FWD) begin
                  held_drive_nxt = -$signed({1'b0, drive_level_r});
                  phase_nxt      = ecc_pkg::PH_SET_REV;
                end else begin
                  held_drive_nxt = pos_positive ? -$signed({1'b0, center_level_r})
                                                : $signed({1'b0, center_level_r});
                  phase_nxt      = ecc_pkg::PH_CENTER;
                end
              end
            end
            ecc_pkg::PH_CENTER: begin
              if (center_ok) begin
                record_valid_nxt = 1'b1;
                held_drive_nxt   = '0;
                phase_nxt        = ecc_pkg::PH_INIT;
                done_o_nxt       = 1'b1;
              end
            end
            default: begin
            end
          endcase
          strobe_nxt  = 1'b1;
          drive_o_nxt = held_drive_nxt;
          state_nxt   = ST_IDLE;
        end
      end
      ST_RDATA: begin
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        strobe_nxt  = 1'b1;
        drive_o_nxt = held_drive_r;
        corr_o_nxt  = rd_ok_r ? scaled_sat : 16'sd0;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_CLEAR;
      clr_addr_r        <= '0;
      drive_level_r     <= ecc_pkg::RST_DRIVE_LEVEL;
      center_level_r    <= ecc_pkg::RST_CENTER_LEVEL;
      velocity_margin_r <= ecc_pkg::RST_VELOCITY_MARGIN;
      settle_target_r   <= ecc_pkg::RST_SETTLE_TARGET;
      center_margin_r   <= ecc_pkg::RST_CENTER_MARGIN;
      period_counts_r   <= ecc_pkg::RST_PERIOD_COUNTS;
      smoothing_shift_r <= ecc_pkg::RST_SMOOTHING_SHIFT;
      wrap_length_r     <= ecc_pkg::RST_WRAP_LENGTH;
      phase_r           <= ecc_pkg::PH_INIT;
      held_drive_r      <= '0;
      settle_cnt_r      <= '0;
      sweep_start_r     <= '0;
      filter_acc_r      <= '0;
      record_valid_r    <= 1'b0;
      rd_ok_r           <= 1'b0;
      strobe_r          <= 1'b0;
      rst_o_r           <= 1'b0;
      arm_o_r           <= 1'b0;
      clr_o_r           <= 1'b0;
      done_o_r          <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      clr_addr_r     <= clr_addr_nxt;
      phase_r        <= phase_nxt;
      held_drive_r   <= held_drive_nxt;
      settle_cnt_r   <= settle_cnt_nxt;
      sweep_start_r  <= sweep_start_nxt;
      filter_acc_r   <= filter_acc_nxt;
      record_valid_r <= record_valid_nxt;
      rd_ok_r        <= rd_ok_nxt;
      strobe_r       <= strobe_nxt;
      rst_o_r        <= rst_o_nxt;
      arm_o_r        <= arm_o_nxt;
      clr_o_r        <= clr_o_nxt;
      done_o_r       <= done_o_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ecc_pkg::REG_DRIVE_LEVEL:     drive_level_r     <= cfg_data[14:0];
          ecc_pkg::REG_CENTER_LEVEL:    center_level_r    <= cfg_data[14:0];
          ecc_pkg::REG_VELOCITY_MARGIN: velocity_margin_r <= cfg_data[14:0];
          ecc_pkg::REG_SETTLE_TARGET:   settle_target_r   <= cfg_data;
          ecc_pkg::REG_CENTER_MARGIN:   center_margin_r   <= cfg_data[14:0];
          ecc_pkg::REG_PERIOD_COUNTS:   period_counts_r   <= cfg_data;
          ecc_pkg::REG_SMOOTHING_SHIFT: smoothing_shift_r <= cfg_data[3:0];
          ecc_pkg::REG_WRAP_LENGTH:     wrap_length_r     <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // transaction payload and datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r      <= in_kind;
      speed_r     <= in_speed;
      angle_r     <= in_angle_pos;
      rev_pos_r   <= in_rev_pos;
      err_r       <= in_error_sample;
      rev_done_r  <= in_rev_done;
      rdir_r      <= in_reverse_dir;
      quot_prod_r <= PW'(in_rev_pos) * PW'(ecc_pkg::DIV_RECIP);
    end
    if (state_r == ST_RDATA) begin
      scale_prod_r <= 32'(entry) * 32'(ecc_pkg::READ_SCALE);
    end
    drive_o_r <= drive_o_nxt;
    corr_o_r  <= corr_o_nxt;
  end

  assign out_strobe            = strobe_r;
  assign out_drive_out         = drive_o_r;
  assign out_reset_ctrl        = rst_o_r;
  assign out_arm_rev           = arm_o_r;
  assign out_clear_rev         = clr_o_r;
  assign out_done_res          = done_o_r;
  assign out_scaled_correction = corr_o_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without a transaction in flight");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start work");

  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_done_res) |-> (phase_r == ecc_pkg::PH_INIT && record_valid_r))
    else $error("completion reported without sequence restart");

endmodule

`default_nettype wire

>>> design/ecc_ram.sv
`default_nettype none

module ecc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
